// ===== rtl/psg_pkg.sv =====
package psg_pkg;

  // Item operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RUN   = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_PWM_MODE   = 2'd0;
  localparam logic [1:0] CFG_FAST_NOISE = 2'd1;
  localparam logic [1:0] CFG_LEFT_EN    = 2'd2;
  localparam logic [1:0] CFG_RIGHT_EN   = 2'd3;

  // Channel numbers
  localparam int unsigned NUM_TONES = 3;
  localparam logic [1:0]  NOISE_CH  = 2'd3;

  // Noise shifter
  localparam logic [15:0] LFSR_TAPS = 16'h0009;
  localparam logic [15:0] LFSR_SEED = 16'h8000;

  // PWM sweep limits, Q0.15
  localparam logic [14:0] PWM_TOP  = 15'd32767;
  localparam logic [14:0] PWM_HIGH = 15'd32382;
  localparam logic [14:0] PWM_LOW  = 15'd4915;

  // Upper six bits of a tone period
  localparam logic [9:0] TONE_HIGH_MASK = 10'h3F0;

  // Running state of one tone channel
  typedef struct packed {
    logic signed [15:0] cnt;
    logic [14:0]        pwm;
    logic               rising;
    logic               neg;
  } tone_state_t;

endpackage

// ===== rtl/psg_tone_ch.sv =====
module psg_tone_ch
  import psg_pkg::*;
(
  input  logic        pwm_mode,
  input  logic [9:0]  period,
  input  logic [7:0]  cyc,
  input  tone_state_t st,
  output tone_state_t st_nxt
);

  logic               active;
  logic [14:0]        pwm_new;
  logic               rising_new;
  logic [15:0]        pwm_inc;
  logic signed [17:0] diff;
  logic signed [17:0] reload;
  logic signed [17:0] sum;
  logic signed [15:0] cnt_new;
  logic [24:0]        prod;
  logic [13:0]        thr;

  assign active = (st.cnt > 16'sd0) || (period != 10'd0);

  // Step the PWM level, turning at either limit
  assign pwm_inc = {1'b0, st.pwm} + 16'd1;
  always_comb begin
    pwm_new    = st.pwm;
    rising_new = st.rising;
    if (st.rising) begin
      if (pwm_inc > {1'b0, PWM_HIGH}) begin
        pwm_new    = PWM_TOP;
        rising_new = 1'b0;
      end else begin
        pwm_new = pwm_inc[14:0];
      end
    end else begin
      if (st.pwm <= PWM_LOW) begin
        pwm_new    = PWM_LOW;
        rising_new = 1'b1;
      end else begin
        pwm_new = st.pwm - 15'd1;
      end
    end
  end

  // Count down, reload on reaching zero, saturate below
  assign diff   = {{2{st.cnt[15]}}, st.cnt} - $signed({10'd0, cyc});
  assign reload = pwm_mode ? $signed({3'd0, period, 5'd0}) : $signed({4'd0, period, 4'd0});
  assign sum    = (diff <= 18'sd0) ? diff + reload : diff;
  assign cnt_new = (sum < -18'sd32768) ? -16'sd32768 : sum[15:0];

  // Duty threshold: period * 16 * level >> 15
  assign prod = period * pwm_new;
  assign thr  = prod[24:11];

  always_comb begin
    st_nxt = st;
    if (pwm_mode) begin
      st_nxt.pwm    = pwm_new;
      st_nxt.rising = rising_new;
      if (active) begin
        st_nxt.cnt = cnt_new;
        st_nxt.neg = (cnt_new < $signed({2'b00, thr}));
      end
    end else if (active) begin
      st_nxt.cnt = cnt_new;
      if ((diff <= 18'sd0) && (period != 10'd1)) begin
        st_nxt.neg = ~st.neg;
      end
    end
  end

endmodule

// ===== rtl/psg_tone_noise_generator_unit.sv =====
// Three-tone plus noise sound generator. Each request either writes one byte
// to the sound port (latch or data byte) or advances every channel counter by
// a number of clock cycles; each request returns one stereo sample pair, the
// sum of the enabled channels' signed levels. One request is taken per clock:
// the whole state update, including the PWM duty multiply, is combinational
// between the state registers, and the sample pair is held in an output
// register from the cycle after acceptance. in_ready stays high while that
// register is empty or being read, so requests flow back to back.
module psg_tone_noise_generator_unit
  import psg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [7:0]        in_port_byte,
  input  logic [7:0]        in_cycles,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [6:0] out_left_sample,
  output logic signed [6:0] out_right_sample
);

  // Configuration
  logic       pwm_mode_r;
  logic       fast_noise_r;
  logic [3:0] left_en_r;
  logic [3:0] right_en_r;

  // Channel state
  logic [9:0]         tone_period_r [NUM_TONES];
  logic [9:0]         tone_period_nxt [NUM_TONES];
  tone_state_t        tone_r [NUM_TONES];
  tone_state_t        tone_run [NUM_TONES];
  tone_state_t        tone_nxt [NUM_TONES];
  logic [3:0]         atten_r [4];
  logic [3:0]         atten_nxt [4];
  logic signed [15:0] noise_cnt_r, noise_cnt_nxt;
  logic [15:0]        noise_sr_r, noise_sr_nxt;
  logic               noise_white_r, noise_white_nxt;
  logic [1:0]         noise_rate_r, noise_rate_nxt;
  logic               noise_half_r, noise_half_nxt;
  logic               noise_neg_r, noise_neg_nxt;
  logic [1:0]         sel_ch_r, sel_ch_nxt;
  logic               sel_vol_r, sel_vol_nxt;

  // Output stage
  logic              out_valid_r;
  logic signed [6:0] left_r, left_nxt;
  logic signed [6:0] right_r, right_nxt;

  logic               accept;
  logic               is_latch;
  logic [5:0]         wr_data;
  logic signed [17:0] n_diff;
  logic signed [17:0] n_reload;
  logic signed [17:0] n_sum;
  logic               n_wrap;
  logic               ch_neg [4];
  logic signed [6:0]  lvl [4];

  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  // Advance each tone channel
  for (genvar g = 0; g < NUM_TONES; g++) begin : g_tone
    psg_tone_ch u_tone (
      .pwm_mode (pwm_mode_r),
      .period   (tone_period_r[g]),
      .cyc      (in_cycles),
      .st       (tone_r[g]),
      .st_nxt   (tone_run[g])
    );
  end

  // Noise countdown and reload
  assign n_diff = {{2{noise_cnt_r[15]}}, noise_cnt_r} - $signed({10'd0, in_cycles});
  assign n_wrap = (n_diff <= 18'sd0);
  always_comb begin
    case (noise_rate_r)
      2'd0:    n_reload = fast_noise_r ? 18'sd16 : 18'sd256;
      2'd1:    n_reload = fast_noise_r ? 18'sd32 : 18'sd512;
      2'd2:    n_reload = fast_noise_r ? 18'sd64 : 18'sd1024;
      default: n_reload = $signed({4'd0, tone_period_r[2], 4'd0});
    endcase
  end
  assign n_sum = n_wrap ? n_diff + n_reload : n_diff;

  // Decode the port byte
  assign is_latch = in_port_byte[7];
  assign wr_data  = is_latch ? {2'b00, in_port_byte[3:0]} : in_port_byte[5:0];

  always_comb begin
    for (int i = 0; i < NUM_TONES; i++) begin
      tone_period_nxt[i] = tone_period_r[i];
      tone_nxt[i]        = tone_r[i];
    end
    for (int i = 0; i < 4; i++) begin
      atten_nxt[i] = atten_r[i];
    end
    noise_cnt_nxt   = noise_cnt_r;
    noise_sr_nxt    = noise_sr_r;
    noise_white_nxt = noise_white_r;
    noise_rate_nxt  = noise_rate_r;
    noise_half_nxt  = noise_half_r;
    noise_neg_nxt   = noise_neg_r;
    sel_ch_nxt      = sel_ch_r;
    sel_vol_nxt     = sel_vol_r;

    if (in_operation == OP_WRITE) begin
      if (is_latch) begin
        sel_ch_nxt  = in_port_byte[6:5];
        sel_vol_nxt = in_port_byte[4];
      end
      if (sel_vol_nxt) begin
        for (int i = 0; i < 4; i++) begin
          if (sel_ch_nxt == 2'(i)) atten_nxt[i] = wr_data[3:0];
        end
      end else if (sel_ch_nxt == NOISE_CH) begin
        // Noise control restarts the shifter
        noise_sr_nxt    = LFSR_SEED;
        noise_rate_nxt  = wr_data[1:0];
        noise_white_nxt = wr_data[2];
      end else begin
        for (int i = 0; i < NUM_TONES; i++) begin
          if (sel_ch_nxt == 2'(i)) begin
            if (is_latch) begin
              tone_period_nxt[i] = (tone_period_r[i] & TONE_HIGH_MASK) | {6'd0, wr_data[3:0]};
            end else begin
              tone_period_nxt[i] = (tone_period_r[i] & ~TONE_HIGH_MASK) | {wr_data, 4'd0};
            end
          end
        end
      end
    end else begin
      for (int i = 0; i < NUM_TONES; i++) begin
        tone_nxt[i] = tone_run[i];
      end
      noise_cnt_nxt = (n_sum < -18'sd32768) ? -16'sd32768 : n_sum[15:0];
      if (n_wrap) begin
        noise_half_nxt = ~noise_half_r;
        if (!noise_half_r) begin
          // Shift on every second wrap
          noise_neg_nxt = ~noise_sr_r[0];
          noise_sr_nxt  = {noise_white_r ? ^(noise_sr_r & LFSR_TAPS) : noise_sr_r[0],
                           noise_sr_r[15:1]};
        end
      end
    end
  end

  // Mix the stereo pair from the updated state
  always_comb begin
    for (int i = 0; i < NUM_TONES; i++) begin
      ch_neg[i] = tone_nxt[i].neg;
    end
    ch_neg[3] = noise_neg_nxt;
    for (int i = 0; i < 4; i++) begin
      lvl[i] = $signed({3'b000, 4'hF - atten_nxt[i]});
      if (ch_neg[i]) lvl[i] = -lvl[i];
    end
    left_nxt  = 7'sd0;
    right_nxt = 7'sd0;
    for (int i = 0; i < 4; i++) begin
      if (left_en_r[i])  left_nxt  = left_nxt + lvl[i];
      if (right_en_r[i]) right_nxt = right_nxt + lvl[i];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_mode_r   <= 1'b0;
      fast_noise_r <= 1'b0;
      left_en_r    <= 4'hF;
      right_en_r   <= 4'hF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PWM_MODE:   pwm_mode_r   <= cfg_data[0];
        CFG_FAST_NOISE: fast_noise_r <= cfg_data[0];
        CFG_LEFT_EN:    left_en_r    <= cfg_data;
        CFG_RIGHT_EN:   right_en_r   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Channel state, updated on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TONES; i++) begin
        tone_period_r[i] <= 10'd0;
        tone_r[i]        <= '{cnt: 16'sd0, pwm: PWM_LOW, rising: 1'b1, neg: 1'b0};
      end
      for (int i = 0; i < 4; i++) begin
        atten_r[i] <= 4'hF;
      end
      noise_cnt_r   <= 16'sd0;
      noise_sr_r    <= LFSR_SEED;
      noise_white_r <= 1'b0;
      noise_rate_r  <= 2'd0;
      noise_half_r  <= 1'b0;
      noise_neg_r   <= 1'b0;
      sel_ch_r      <= 2'd0;
      sel_vol_r     <= 1'b0;
    end else if (accept) begin
      for (int i = 0; i < NUM_TONES; i++) begin
        tone_period_r[i] <= tone_period_nxt[i];
        tone_r[i]        <= tone_nxt[i];
      end
      for (int i = 0; i < 4; i++) begin
        atten_r[i] <= atten_nxt[i];
      end
      noise_cnt_r   <= noise_cnt_nxt;
      noise_sr_r    <= noise_sr_nxt;
      noise_white_r <= noise_white_nxt;
      noise_rate_r  <= noise_rate_nxt;
      noise_half_r  <= noise_half_nxt;
      noise_neg_r   <= noise_neg_nxt;
      sel_ch_r      <= sel_ch_nxt;
      sel_vol_r     <= sel_vol_nxt;
    end
  end

  // Hold the sample pair until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = left_r;
  assign out_right_sample = right_r;

endmodule

// ===== rtl/psg_chk.sv =====
module psg_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [6:0] out_left_sample,
  input logic signed [6:0] out_right_sample
);

  // Output stage empty means a request can always enter
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output stage");

  // Every accepted request yields a sample pair next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted request gave no result");

  // Samples stay within the four-channel range
  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_sample >= -7'sd60) && (out_left_sample <= 7'sd60) &&
                  (out_right_sample >= -7'sd60) && (out_right_sample <= 7'sd60))
    else $error("sample out of range");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_left_sample) &&
                                  $stable(out_right_sample))
    else $error("stalled result changed");

endmodule

bind psg_tone_noise_generator_unit psg_chk u_psg_chk (.*);

// ===== dv/psg_sample_checker.sv =====
`timescale 1ns / 100ps

module psg_sample_checker
  import psg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_operation,
  input  logic [7:0]        in_port_byte,
  input  logic [7:0]        in_cycles,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic signed [6:0] out_left_sample,
  input  logic signed [6:0] out_right_sample,
  output int                mismatch_count,
  output int                samples_pending
);

  // Noise rate that borrows the tone 2 period
  localparam logic [1:0] NOISE_RATE_TONE2 = 2'd3;

  typedef struct packed {
    logic signed [6:0] left;
    logic signed [6:0] right;
  } stereo_sample_t;

  stereo_sample_t expected_samples[$];

  // Shadow configuration
  logic       pwm_mode;
  logic       fast_noise;
  logic [3:0] left_en;
  logic [3:0] right_en;

  // Shadow channel state
  logic [9:0]  period[3];
  int          count[3];
  int          pwm_lvl[3];
  logic        pwm_up[3];
  logic        negative[4];
  logic [3:0]  atten[4];
  int          noise_cnt;
  logic [15:0] shifter;
  logic        white;
  logic [1:0]  rate;
  logic        half;
  logic [1:0]  sel_ch;
  logic        sel_vol;

  function automatic int clamp_count(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic void reset_state();
    pwm_mode   = 1'b0;
    fast_noise = 1'b0;
    left_en    = 4'hF;
    right_en   = 4'hF;
    for (int c = 0; c < NUM_TONES; c++) begin
      period[c]  = '0;
      count[c]   = 0;
      pwm_lvl[c] = int'(PWM_LOW);
      pwm_up[c]  = 1'b1;
    end
    for (int c = 0; c < 4; c++) begin
      negative[c] = 1'b0;
      atten[c]    = 4'hF;
    end
    noise_cnt = 0;
    shifter   = LFSR_SEED;
    white     = 1'b0;
    rate      = '0;
    half      = 1'b0;
    sel_ch    = '0;
    sel_vol   = 1'b0;
  endfunction

  // Decode one sound port byte: latch bytes select channel and type first
  function automatic void write_port(logic [7:0] b);
    logic [5:0] data;
    logic       is_latch;
    is_latch = b[7];
    if (is_latch) begin
      sel_ch  = b[6:5];
      sel_vol = b[4];
      data    = {2'b00, b[3:0]};
    end else begin
      data = b[5:0];
    end
    if (sel_vol) begin
      atten[sel_ch] = data[3:0];
    end else if (sel_ch == NOISE_CH) begin
      shifter = LFSR_SEED;
      rate    = data[1:0];
      white   = data[2];
    end else if (is_latch) begin
      period[sel_ch] = (period[sel_ch] & TONE_HIGH_MASK) | {6'd0, data[3:0]};
    end else begin
      period[sel_ch] = {data, period[sel_ch][3:0]};
    end
  endfunction

  function automatic void advance_tone(int ch, int cyc);
    int per;
    int cnt;
    int thr;
    per = int'(period[ch]);
    cnt = count[ch];
    if (pwm_mode) begin
      // Sweep the duty level one step, bouncing between the limits
      if (pwm_up[ch]) begin
        pwm_lvl[ch]++;
        if (pwm_lvl[ch] > int'(PWM_HIGH)) begin
          pwm_lvl[ch] = int'(PWM_TOP);
          pwm_up[ch]  = 1'b0;
        end
      end else begin
        pwm_lvl[ch]--;
        if (pwm_lvl[ch] < int'(PWM_LOW)) begin
          pwm_lvl[ch] = int'(PWM_LOW);
          pwm_up[ch]  = 1'b1;
        end
      end
      if (cnt > 0 || per > 0) begin
        cnt -= cyc;
        if (cnt <= 0) cnt += per * 32;
        cnt       = clamp_count(cnt);
        count[ch] = cnt;
        thr       = int'((longint'(per) * 16 * longint'(pwm_lvl[ch])) >>> 15);
        negative[ch] = (cnt < thr);
      end
    end else if (cnt > 0 || per > 0) begin
      cnt -= cyc;
      if (cnt <= 0) begin
        cnt += per * 16;
        // A period of one holds the level
        if (per != 1) negative[ch] = ~negative[ch];
      end
      count[ch] = clamp_count(cnt);
    end
  endfunction

  function automatic void advance_noise(int cyc);
    int   cnt;
    int   reload;
    logic fb;
    cnt = noise_cnt - cyc;
    if (cnt <= 0) begin
      if (rate == NOISE_RATE_TONE2) reload = int'(period[2]) * 16;
      else reload = (fast_noise ? 16 : 256) << rate;
      cnt += reload;
      half = ~half;
      // Shift the register on every second reload only
      if (half) begin
        negative[NOISE_CH] = ~shifter[0];
        fb      = white ? (shifter[0] ^ shifter[3]) : shifter[0];
        shifter = {fb, shifter[15:1]};
      end
    end
    noise_cnt = clamp_count(cnt);
  endfunction

  function automatic logic signed [6:0] channel_sum(logic [3:0] en);
    int sum;
    int lvl;
    sum = 0;
    for (int c = 0; c < 4; c++) begin
      lvl = 15 - int'(atten[c]);
      if (en[c]) sum += negative[c] ? -lvl : lvl;
    end
    return 7'(sum);
  endfunction

  function automatic stereo_sample_t predict_sample(logic op, logic [7:0] b, logic [7:0] cyc);
    if (op == OP_WRITE) begin
      write_port(b);
    end else begin
      for (int ch = 0; ch < NUM_TONES; ch++) advance_tone(ch, int'(cyc));
      advance_noise(int'(cyc));
    end
    return '{left: channel_sum(left_en), right: channel_sum(right_en)};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: sample check failed: %s", $time, msg);
    mismatch_count++;
  endtask

  // Compare delivered samples, then track config writes and new requests
  always @(posedge clk) begin
    stereo_sample_t want;
    if (!rst_n) begin
      reset_state();
      expected_samples.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("sample L=%0d R=%0d with no request outstanding",
                                    out_left_sample, out_right_sample));
        end else begin
          want = expected_samples.pop_front();
          if (out_left_sample !== want.left)
            report_mismatch($sformatf("left got %0d, want %0d", out_left_sample, want.left));
          if (out_right_sample !== want.right)
            report_mismatch($sformatf("right got %0d, want %0d", out_right_sample, want.right));
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PWM_MODE:   pwm_mode   = cfg_data[0];
          CFG_FAST_NOISE: fast_noise = cfg_data[0];
          CFG_LEFT_EN:    left_en    = cfg_data;
          CFG_RIGHT_EN:   right_en   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_samples.push_back(predict_sample(in_operation, in_port_byte, in_cycles));
    end
    samples_pending = expected_samples.size();
  end

endmodule

// ===== dv/psg_tone_noise_generator_unit_tb.sv =====
`timescale 1ns / 100ps

module psg_tone_noise_generator_unit_tb
  import psg_pkg::*;
();

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [1:0]        cfg_index;
  logic [3:0]        cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              in_operation;
  logic [7:0]        in_port_byte;
  logic [7:0]        in_cycles;
  logic              out_valid;
  logic              out_ready;
  logic signed [6:0] out_left_sample;
  logic signed [6:0] out_right_sample;

  int         mismatch_count;
  int         samples_pending;
  int         burst_left = 0;
  logic [9:0] stall_phase = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  psg_tone_noise_generator_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_port_byte     (in_port_byte),
    .in_cycles        (in_cycles),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample)
  );

  psg_sample_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_port_byte     (in_port_byte),
    .in_cycles        (in_cycles),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .mismatch_count   (mismatch_count),
    .samples_pending  (samples_pending)
  );

  // Receiver: cycle through always-ready, coin-flip, sparse and mostly-ready
  always @(posedge clk) begin
    stall_phase <= stall_phase + 10'd1;
    case (stall_phase[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (stall_phase[2:0] == 3'd0);
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Issue one request, opening a new burst after a random gap when due
  task automatic send_request(input logic op, input logic [7:0] port_byte,
                              input logic [7:0] cyc);
    int idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_port_byte <= port_byte;
    in_cycles    <= cyc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_write(input logic [7:0] port_byte);
    send_request(OP_WRITE, port_byte, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_run(input logic [7:0] cyc);
    send_request(OP_RUN, 8'($urandom_range(0, 255)), cyc);
  endtask

  // Hold off until every outstanding sample has been delivered
  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (samples_pending != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [3:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic pwm, input logic fast, input logic [3:0] left_en,
                          input logic [3:0] right_en);
    write_register(CFG_PWM_MODE, {3'd0, pwm});
    write_register(CFG_FAST_NOISE, {3'd0, fast});
    write_register(CFG_LEFT_EN, left_en);
    write_register(CFG_RIGHT_EN, right_en);
  endtask

  // Mostly runs and well-formed port writes, biased to short tone periods
  task automatic send_random_item();
    int         pick;
    logic [1:0] ch;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    ch   = 2'($urandom_range(0, 3));
    if (pick < 20) begin
      send_run(8'($urandom_range(0, 16)));
    end else if (pick < 50) begin
      send_run(8'($urandom_range(0, 255)));
    end else if (pick < 65) begin
      send_write({1'b1, ch, 1'b0, 4'($urandom_range(0, 15))});
    end else if (pick < 75) begin
      send_write({1'b1, ch, 1'b1, 4'($urandom_range(0, 15))});
    end else if (pick < 90) begin
      b = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 127));
      send_write(b);
    end else begin
      send_write(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    in_operation <= OP_WRITE;
    in_port_byte <= '0;
    in_cycles    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Open all four channels at full level
    send_write(8'h90);
    send_write(8'hB0);
    send_write(8'hD0);
    send_write(8'hF0);
    send_run(8'd0);
    // Longest tone 0 period; bit 6 of the data byte must be dropped
    send_write(8'h8F);
    send_write(8'h7F);
    // Tone 1 period of one holds its level
    send_write(8'hA1);
    send_write(8'h00);
    // Tone 2 period of zero
    send_write(8'hC0);
    send_write(8'h40);
    // White noise clocked from tone 2
    send_write(8'hE7);
    send_run(8'd255);
    send_run(8'd1);
    send_run(8'd0);
    send_run(8'd255);
    // Data byte after a volume latch sets the attenuation
    send_write(8'hF5);
    send_write(8'h0A);
    // Noise control rewritten through a data byte
    send_write(8'hE4);
    send_write(8'h03);
    send_run(8'd255);
    send_run(8'd128);

    // Random phases under several register settings, extremes first
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: set_mode(1'b1, 1'b0, 4'hF, 4'hF);
        1: set_mode(1'b0, 1'b1, 4'h0, 4'hF);
        2: set_mode(1'b1, 1'b1, 4'hF, 4'h0);
        3: set_mode(1'b0, 1'b0, 4'h0, 4'h0);
        default: set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      for (int k = 0; k < 200; k++) begin
        if (k == 100) wait_drained();
        send_random_item();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== psg_tone_noise_generator_unit.f =====
rtl/psg_pkg.sv
rtl/psg_tone_ch.sv
rtl/psg_tone_noise_generator_unit.sv
rtl/psg_chk.sv
dv/psg_sample_checker.sv
dv/psg_tone_noise_generator_unit_tb.sv
